// ===== sv/ucs_pkg.sv =====
package ucs_pkg;

	localparam int MAX_URL_LEN_DEF = 1024;
	localparam int AUTH_BUF_LEN = 512;

	localparam logic [30:0] PORT_MAX = '1;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_AT    = 8'h40;

	typedef enum logic [2:0] {
		PART_SCHEME   = 3'd0,
		PART_HOST     = 3'd1,
		PART_PORT     = 3'd2,
		PART_USER     = 3'd3,
		PART_PASS     = 3'd4,
		PART_PATH     = 3'd5,
		PART_QUERY    = 3'd6,
		PART_FRAGMENT = 3'd7
	} part_t;

	typedef struct packed {
		logic scheme;
		logic auth;
		logic authend;
		logic at;
		logic pcolon;
		logic portcolon;
		logic query;
		logic frag;
	} flags_t;

endpackage

// ===== sv/ucs_in_if.sv =====
interface ucs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] url_byte;
	logic       end_of_url;

	modport source (output valid, output url_byte, output end_of_url, input ready);
	modport sink (input valid, input url_byte, input end_of_url, output ready);
endinterface

// ===== sv/ucs_out_if.sv =====
interface ucs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  part_code;
	logic        present;
	logic [9:0]  start_offset;
	logic [10:0] span_length;
	logic [30:0] port_number;
	logic        too_long;
	logic        final_part;

	modport source (
		output valid, output part_code, output present, output start_offset,
		output span_length, output port_number, output too_long, output final_part,
		input ready
	);
	modport sink (
		input valid, input part_code, input present, input start_offset,
		input span_length, input port_number, input too_long, input final_part,
		output ready
	);
endinterface

// ===== sv/ucs_parser.sv =====
module ucs_parser #(
	parameter int MAX_URL_LEN = ucs_pkg::MAX_URL_LEN_DEF,
	parameter type snap_t = logic
) (
	input  logic    clk,
	input  logic    arst_n,
	ucs_in_if.sink  url_bytes,
	input  logic    snap_busy,
	output logic    snap_load,
	output snap_t   snap
);

	localparam int PosW = $clog2(MAX_URL_LEN + 1);
	localparam int AuthLim = ucs_pkg::AUTH_BUF_LEN - 1;

	typedef enum logic [5:0] {
		PH_SCHEME = 6'b000001,
		PH_SLASH1 = 6'b000010,
		PH_SLASH2 = 6'b000100,
		PH_AUTH   = 6'b001000,
		PH_REST   = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	typedef enum logic [3:0] {
		PS_BLANK = 4'b0001,
		PS_SIGN  = 4'b0010,
		PS_DIGIT = 4'b0100,
		PS_STOP  = 4'b1000
	} pstage_t;

	typedef struct packed {
		phase_t  ph;
		pstage_t pstage;
		snap_t   s;
	} pst_t;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eou_s1;
	logic       adv;
	pst_t       st_q;
	pst_t       nxt;

	function automatic logic is_alpha(logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= ucs_pkg::CH_ZERO && b <= ucs_pkg::CH_NINE;
	endfunction

	function automatic logic is_blank(logic [7:0] b);
		return b == ucs_pkg::CH_SPACE || (b >= ucs_pkg::CH_TAB && b <= ucs_pkg::CH_CR);
	endfunction

	function automatic pst_t clear_state();
		pst_t r;
		r = '0;
		r.ph = PH_SCHEME;
		r.pstage = PS_BLANK;
		return r;
	endfunction

	function automatic pst_t rest_byte(pst_t x, logic [PosW-1:0] pos, logic [7:0] b);
		pst_t r;
		r = x;
		if (b == ucs_pkg::CH_HASH && !x.s.f.frag) begin
			r.s.frag_pos = pos;
			r.s.f.frag = 1'b1;
		end else if (b == ucs_pkg::CH_QMARK && !x.s.f.query && !x.s.f.frag) begin
			r.s.query_pos = pos;
			r.s.f.query = 1'b1;
		end
		return r;
	endfunction

	function automatic pst_t port_feed(pst_t x, logic [7:0] b);
		pst_t        r;
		logic [34:0] t;
		r = x;
		t = ({4'b0, x.s.acc} << 3) + ({4'b0, x.s.acc} << 1) + 35'(b - ucs_pkg::CH_ZERO);
		if (x.pstage == PS_BLANK && is_blank(b)) begin
			r.pstage = PS_BLANK;
		end else if (x.pstage == PS_BLANK &&
				(b == ucs_pkg::CH_PLUS || b == ucs_pkg::CH_MINUS)) begin
			r.s.neg = (b == ucs_pkg::CH_MINUS);
			r.pstage = PS_SIGN;
		end else if (x.pstage != PS_STOP && is_digit(b)) begin
			r.pstage = PS_DIGIT;
			r.s.acc = (t > 35'(ucs_pkg::PORT_MAX)) ? ucs_pkg::PORT_MAX : t[30:0];
		end else begin
			r.pstage = PS_STOP;
		end
		return r;
	endfunction

	function automatic pst_t auth_byte(pst_t x, logic [PosW-1:0] pos, logic [7:0] b);
		pst_t            r;
		logic [PosW-1:0] diff;
		r = x;
		diff = pos - x.s.auth_start;
		if (32'(diff) < 32'(AuthLim)) begin
			if (b == ucs_pkg::CH_AT) begin
				r.s.at_pos = pos;
				r.s.f.at = 1'b1;
				r.s.f.portcolon = 1'b0;
				r.s.acc = '0;
				r.s.neg = 1'b0;
				r.pstage = PS_BLANK;
			end else if (b == ucs_pkg::CH_COLON && !x.s.f.portcolon) begin
				if (!x.s.f.pcolon) begin
					r.s.pcolon_pos = pos;
					r.s.f.pcolon = 1'b1;
				end
				r.s.portcolon_pos = pos;
				r.s.f.portcolon = 1'b1;
				r.s.acc = '0;
				r.s.neg = 1'b0;
				r.pstage = PS_BLANK;
			end else begin
				if (b == ucs_pkg::CH_COLON && !x.s.f.pcolon) begin
					r.s.pcolon_pos = pos;
					r.s.f.pcolon = 1'b1;
				end
				if (x.s.f.portcolon) begin
					r = port_feed(r, b);
				end
			end
		end
		return r;
	endfunction

	function automatic pst_t take_byte(pst_t x, logic [PosW-1:0] pos, logic [7:0] b);
		pst_t r;
		r = x;
		unique case (x.ph)
			PH_SCHEME: begin
				if (pos == '0) begin
					if (!is_alpha(b)) begin
						r.ph = PH_REST;
						r = rest_byte(r, pos, b);
					end
				end else if (b == ucs_pkg::CH_COLON) begin
					r.s.scheme_pos = pos;
					r.s.f.scheme = 1'b1;
					r.ph = PH_SLASH1;
				end else if (!(is_alpha(b) || is_digit(b) || b == ucs_pkg::CH_PLUS ||
						b == ucs_pkg::CH_DOT || b == ucs_pkg::CH_MINUS)) begin
					r.ph = PH_REST;
					r = rest_byte(r, pos, b);
				end
			end
			PH_SLASH1: begin
				if (b == ucs_pkg::CH_SLASH) begin
					r.ph = PH_SLASH2;
				end else begin
					r.ph = PH_REST;
					r = rest_byte(r, pos, b);
				end
			end
			PH_SLASH2: begin
				if (b == ucs_pkg::CH_SLASH) begin
					r.ph = PH_AUTH;
					r.s.f.auth = 1'b1;
					r.s.auth_start = pos + 1'b1;
				end else begin
					r.ph = PH_REST;
					r = rest_byte(r, pos, b);
				end
			end
			PH_AUTH: begin
				if (b == ucs_pkg::CH_SLASH || b == ucs_pkg::CH_QMARK ||
						b == ucs_pkg::CH_HASH) begin
					r.s.auth_end = pos;
					r.s.f.authend = 1'b1;
					r.ph = PH_REST;
					r = rest_byte(r, pos, b);
				end else begin
					r = auth_byte(r, pos, b);
				end
			end
			default: begin
				r = rest_byte(r, pos, b);
			end
		endcase
		return r;
	endfunction

	assign adv = valid_s1 && (!eou_s1 || !snap_busy);
	assign url_bytes.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (url_bytes.ready) begin
			valid_s1 <= url_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (url_bytes.valid && url_bytes.ready) begin
			byte_s1 <= url_bytes.url_byte;
			eou_s1 <= url_bytes.end_of_url;
		end
	end

	always_comb begin
		nxt = st_q;
		if (st_q.ph != PH_DONE) begin
			if (byte_s1 == ucs_pkg::CH_NUL) begin
				nxt.ph = PH_DONE;
			end else if (32'(st_q.s.tl) >= 32'(MAX_URL_LEN)) begin
				nxt.s.too_long = 1'b1;
			end else begin
				nxt = take_byte(st_q, st_q.s.tl, byte_s1);
				nxt.s.tl = st_q.s.tl + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clear_state();
		end else if (adv) begin
			st_q <= eou_s1 ? clear_state() : nxt;
		end
	end

	assign snap = nxt.s;
	assign snap_load = adv && eou_s1;

endmodule

// ===== sv/ucs_emitter.sv =====
module ucs_emitter #(
	parameter int MAX_URL_LEN = ucs_pkg::MAX_URL_LEN_DEF,
	parameter type snap_t = logic
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       snap_load,
	input  snap_t      snap,
	output logic       snap_busy,
	ucs_out_if.source  spans
);

	localparam int PosW = $clog2(MAX_URL_LEN + 1);
	localparam int AuthLim = ucs_pkg::AUTH_BUF_LEN - 1;

	snap_t            snap_q;
	logic             snap_v_q;
	ucs_pkg::part_t   part_q;
	logic             load_out;

	logic             out_v_q;
	logic [2:0]       part_code_q;
	logic             present_q;
	logic [9:0]       start_q;
	logic [10:0]      len_q;
	logic [30:0]      port_q;
	logic             too_long_q;
	logic             final_q;

	logic [PosW-1:0]  ae, alen, cend, hs, he, ue, rest_start, path_end, q_end;
	logic [PosW-1:0]  st, en, len;
	logic             pass_ok, pres;
	logic [30:0]      port;

	assign snap_busy = snap_v_q;
	assign load_out = snap_v_q && (!out_v_q || spans.ready);

	always_comb begin
		ae = snap_q.f.authend ? snap_q.auth_end : snap_q.tl;
		alen = ae - snap_q.auth_start;
		if (32'(alen) > 32'(AuthLim)) begin
			alen = PosW'(AuthLim);
		end
		cend = snap_q.auth_start + alen;
		pass_ok = snap_q.f.at && snap_q.f.pcolon && (snap_q.pcolon_pos < snap_q.at_pos);
		hs = snap_q.f.at ? snap_q.at_pos + 1'b1 : snap_q.auth_start;
		he = snap_q.f.portcolon ? snap_q.portcolon_pos : cend;
		ue = pass_ok ? snap_q.pcolon_pos : snap_q.at_pos;
		if (snap_q.f.auth) begin
			rest_start = snap_q.f.authend ? snap_q.auth_end : snap_q.tl;
		end else begin
			rest_start = snap_q.f.scheme ? snap_q.scheme_pos + 1'b1 : '0;
		end
		if (rest_start > snap_q.tl) begin
			rest_start = snap_q.tl;
		end
		path_end = snap_q.f.query ? snap_q.query_pos :
			(snap_q.f.frag ? snap_q.frag_pos : snap_q.tl);
		q_end = snap_q.f.frag ? snap_q.frag_pos : snap_q.tl;

		port = '0;
		unique case (part_q)
			ucs_pkg::PART_SCHEME: begin
				pres = snap_q.f.scheme;
				st = '0;
				en = snap_q.scheme_pos;
			end
			ucs_pkg::PART_HOST: begin
				pres = snap_q.f.auth && (he > hs);
				st = hs;
				en = he;
			end
			ucs_pkg::PART_PORT: begin
				pres = snap_q.f.auth && snap_q.f.portcolon && !snap_q.neg &&
					(snap_q.acc != '0);
				st = snap_q.portcolon_pos + 1'b1;
				en = cend;
				port = snap_q.acc;
			end
			ucs_pkg::PART_USER: begin
				pres = snap_q.f.auth && snap_q.f.at && (ue > snap_q.auth_start);
				st = snap_q.auth_start;
				en = ue;
			end
			ucs_pkg::PART_PASS: begin
				pres = snap_q.f.auth && pass_ok &&
					(snap_q.at_pos > snap_q.pcolon_pos + 1'b1);
				st = snap_q.pcolon_pos + 1'b1;
				en = snap_q.at_pos;
			end
			ucs_pkg::PART_PATH: begin
				pres = 1'b1;
				st = rest_start;
				en = path_end;
			end
			ucs_pkg::PART_QUERY: begin
				pres = snap_q.f.query && (q_end > snap_q.query_pos + 1'b1);
				st = snap_q.query_pos + 1'b1;
				en = q_end;
			end
			default: begin
				pres = snap_q.f.frag && (snap_q.tl > snap_q.frag_pos + 1'b1);
				st = snap_q.frag_pos + 1'b1;
				en = snap_q.tl;
			end
		endcase
		len = en - st;
		if (!pres) begin
			st = '0;
			len = '0;
			port = '0;
		end
		if (len == '0) begin
			st = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_load) begin
			snap_q <= snap;
		end
		if (load_out) begin
			part_code_q <= part_q;
			present_q <= pres;
			start_q <= 10'(st);
			len_q <= 11'(len);
			port_q <= port;
			too_long_q <= snap_q.too_long;
			final_q <= (part_q == ucs_pkg::PART_FRAGMENT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_q <= 1'b0;
			part_q <= ucs_pkg::PART_SCHEME;
			out_v_q <= 1'b0;
		end else begin
			if (snap_load) begin
				snap_v_q <= 1'b1;
				part_q <= ucs_pkg::PART_SCHEME;
			end else if (load_out) begin
				part_q <= ucs_pkg::part_t'(part_q + 3'd1);
				if (part_q == ucs_pkg::PART_FRAGMENT) begin
					snap_v_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (spans.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign spans.valid = out_v_q;
	assign spans.part_code = part_code_q;
	assign spans.present = present_q;
	assign spans.start_offset = start_q;
	assign spans.span_length = len_q;
	assign spans.port_number = port_q;
	assign spans.too_long = too_long_q;
	assign spans.final_part = final_q;

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		snap_load |-> !snap_v_q)
		else $error("snapshot overwritten while parts still pending");

	a_load_starts_scheme: assert property (@(posedge clk) disable iff (!arst_n)
		snap_load |=> (snap_v_q && part_q == ucs_pkg::PART_SCHEME))
		else $error("part sequence not restarted on snapshot load");

	a_final_on_fragment: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (final_q == (part_code_q == ucs_pkg::PART_FRAGMENT)))
		else $error("final flag not on fragment part");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !present_q) |-> (start_q == '0 && len_q == '0 && port_q == '0))
		else $error("absent part carries nonzero span");

	a_empty_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && len_q == '0) |-> (start_q == '0))
		else $error("empty span with nonzero start");

endmodule

// ===== sv/url_component_splitter.sv =====
// URL component splitter.
// url_bytes: one URL character per transfer; end_of_url marks the last byte.
//   A zero byte ends the text; bytes after it up to end_of_url are dropped.
// spans: eight transfers per URL, in part order scheme, host, port, user,
//   pass, path, query, fragment; final_part is set on the fragment transfer.
// Throughput: one byte per cycle. Each byte passes an input register and then
//   the position-tracking state register; the parser never waits on the output side
//   except with an end_of_url byte while the previous URL's parts are still
//   being sent, since one snapshot register holds a finished URL.
// Output: after the end_of_url transfer the scheme part passes the input
//   register, the snapshot register and the output register; the other parts
//   follow one per cycle while spans.ready is high, from the single result register.
// Reset: arst_n clears the parse state and the input, snapshot and output valid flags;
//   no parts are pending afterwards.
// Stall: while spans.ready is low the current part holds, the snapshot waits,
//   and the input keeps taking bytes of the next URL until its end byte.
module url_component_splitter #(
	parameter int MAX_URL_LEN = ucs_pkg::MAX_URL_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ucs_in_if.sink     url_bytes,
	ucs_out_if.source  spans
);

	localparam int PosW = $clog2(MAX_URL_LEN + 1);

	typedef struct packed {
		logic [PosW-1:0]  tl;
		logic [PosW-1:0]  scheme_pos;
		logic [PosW-1:0]  auth_start;
		logic [PosW-1:0]  auth_end;
		logic [PosW-1:0]  at_pos;
		logic [PosW-1:0]  pcolon_pos;
		logic [PosW-1:0]  portcolon_pos;
		logic [PosW-1:0]  query_pos;
		logic [PosW-1:0]  frag_pos;
		logic [30:0]      acc;
		logic             neg;
		logic             too_long;
		ucs_pkg::flags_t  f;
	} snap_t;

	snap_t snap;
	logic  snap_load;
	logic  snap_busy;

	ucs_parser #(
		.MAX_URL_LEN (MAX_URL_LEN),
		.snap_t      (snap_t)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.url_bytes (url_bytes),
		.snap_busy (snap_busy),
		.snap_load (snap_load),
		.snap      (snap)
	);

	ucs_emitter #(
		.MAX_URL_LEN (MAX_URL_LEN),
		.snap_t      (snap_t)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_load (snap_load),
		.snap      (snap),
		.snap_busy (snap_busy),
		.spans     (spans)
	);

endmodule
